@@ hdl/qfb_pkg.sv @@
// ----------------------------------------------------------------------------
// qfb_pkg: quaternion-from-basis-vectors shared definitions
// Field widths, internal datapath widths, fixed-point constants and the
// side-band record that travels with each beat down the pipeline.
// ----------------------------------------------------------------------------
package qfb_pkg;

    localparam int IN_W    = 16;   // Q2.14 input component
    localparam int OUT_W   = 16;   // Q2.14 output component
    localparam int PROD_W  = 32;   // 16x16 signed product
    localparam int N_W     = 33;   // cross product component, Q.28
    localparam int C_W     = 34;   // unnormalized quaternion component, Q.28
    localparam int MAG_W   = 33;   // |component|
    localparam int SMAG_W  = 31;   // |component| after range shift, < 2^31
    localparam int SQR_W   = 62;   // square of a shifted magnitude
    localparam int SUM_W   = 64;   // sum of four squares
    localparam int ROOT_W  = 32;   // floor(sqrt(sum))
    localparam int REM_W   = 35;   // square-root partial remainder
    localparam int QUO_W   = 15;   // output magnitude bits (0..16384)
    localparam int DIV_W   = 33;   // divisor 2*norm
    localparam int DREM_W  = 34;   // divider partial remainder

    localparam int SQRT_STEPS_DEF = 2;  // root bits per stage
    localparam int DIV_STEPS_DEF  = 2;  // quotient bits per stage

    typedef logic signed [IN_W-1:0]  in_t;
    typedef logic signed [OUT_W-1:0] out_t;
    typedef logic signed [C_W-1:0]   cval_t;

    localparam cval_t Q28_ONE   = cval_t'(1 << 28);
    localparam cval_t TRACE_MIN = cval_t'(1 << 15);
    localparam out_t  OUT_ONE   = out_t'(16384);

    typedef struct packed {
        logic [3:0][SMAG_W-1:0] mag;
        logic [3:0]             neg;
        logic                   ident;
    } side_t;

endpackage

@@ hdl/qfb_front.sv @@
// ----------------------------------------------------------------------------
// qfb_front: matrix build, branch select and sum of squares
// Six stages: products, cross product, branch/components, magnitude and
// range shift, squares, sum of squares.
// ----------------------------------------------------------------------------
module qfb_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  qfb_pkg::in_t                 u_x,
    input  qfb_pkg::in_t                 u_y,
    input  qfb_pkg::in_t                 u_z,
    input  qfb_pkg::in_t                 v_x,
    input  qfb_pkg::in_t                 v_y,
    input  qfb_pkg::in_t                 v_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [qfb_pkg::SUM_W-1:0]    out_sumsq,
    output qfb_pkg::side_t               out_side
);

    localparam int NST = 6;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_src;
    logic [NST:0]   rdy;

    // stage 1
    logic signed [qfb_pkg::PROD_W-1:0] p_reg [6];
    logic signed [qfb_pkg::PROD_W-1:0] p_next [6];
    qfb_pkg::in_t a1_reg [3], a1_next [3];
    qfb_pkg::in_t b1_reg [3], b1_next [3];
    // stage 2
    logic signed [qfb_pkg::N_W-1:0] n_reg [3], n_next [3];
    qfb_pkg::in_t a2_reg [3], b2_reg [3];
    // stage 3
    qfb_pkg::cval_t c_reg [4], c_next [4];
    logic id3_reg, id3_next;
    // stage 4..6
    qfb_pkg::side_t s4_reg, s4_next, s5_reg, s6_reg;
    logic [qfb_pkg::SQR_W-1:0] sq_reg [4], sq_next [4];
    logic [qfb_pkg::SUM_W-1:0] sum_reg, sum_next;

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_src[0] = in_valid;
        for (int i = 1; i < NST; i++)
        begin
            v_src[i] = v_reg[i-1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_sumsq = sum_reg;
    assign out_side  = s6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_src[i];
                end
            end
        end
    end

    // stage 1: the six cross-product terms
    always_comb
    begin
        p_next[0] = qfb_pkg::PROD_W'(u_y) * qfb_pkg::PROD_W'(v_z);
        p_next[1] = qfb_pkg::PROD_W'(u_z) * qfb_pkg::PROD_W'(v_y);
        p_next[2] = qfb_pkg::PROD_W'(u_z) * qfb_pkg::PROD_W'(v_x);
        p_next[3] = qfb_pkg::PROD_W'(u_x) * qfb_pkg::PROD_W'(v_z);
        p_next[4] = qfb_pkg::PROD_W'(u_x) * qfb_pkg::PROD_W'(v_y);
        p_next[5] = qfb_pkg::PROD_W'(u_y) * qfb_pkg::PROD_W'(v_x);
        a1_next[0] = u_x;
        a1_next[1] = u_y;
        a1_next[2] = u_z;
        b1_next[0] = v_x;
        b1_next[1] = v_y;
        b1_next[2] = v_z;
    end

    // stage 2: n = u x v in Q.28
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = qfb_pkg::N_W'(p_reg[2*i]) - qfb_pkg::N_W'(p_reg[2*i+1]);
        end
    end

    // stage 3: trace test, branch choice, s-scaled components
    always_comb
    begin
        qfb_pkg::cval_t ux, uy, uz, vx, vy, vz, nx, ny, nz, tr, arg;
        ux = qfb_pkg::cval_t'(a2_reg[0]) <<< 14;
        uy = qfb_pkg::cval_t'(a2_reg[1]) <<< 14;
        uz = qfb_pkg::cval_t'(a2_reg[2]) <<< 14;
        vx = qfb_pkg::cval_t'(b2_reg[0]) <<< 14;
        vy = qfb_pkg::cval_t'(b2_reg[1]) <<< 14;
        vz = qfb_pkg::cval_t'(b2_reg[2]) <<< 14;
        nx = qfb_pkg::cval_t'(n_reg[0]);
        ny = qfb_pkg::cval_t'(n_reg[1]);
        nz = qfb_pkg::cval_t'(n_reg[2]);
        tr = qfb_pkg::Q28_ONE + ux + vy + nz;
        arg = tr;
        id3_next = 1'b0;
        if (tr > qfb_pkg::TRACE_MIN)
        begin
            c_next[0] = tr;
            c_next[1] = vz - ny;
            c_next[2] = nx - uz;
            c_next[3] = uy - vx;
        end
        else
        begin
            if (ux > vy && ux > nz)
            begin
                arg = qfb_pkg::Q28_ONE + ux - vy - nz;
                c_next[0] = vz - ny;
                c_next[1] = arg;
                c_next[2] = uy + vx;
                c_next[3] = nx + uz;
            end
            else if (vy > nz)
            begin
                arg = qfb_pkg::Q28_ONE - ux + vy - nz;
                c_next[0] = nx - uz;
                c_next[1] = uy + vx;
                c_next[2] = arg;
                c_next[3] = vz + ny;
            end
            else
            begin
                arg = qfb_pkg::Q28_ONE - ux - vy + nz;
                c_next[0] = uy - vx;
                c_next[1] = nx + uz;
                c_next[2] = vz + ny;
                c_next[3] = arg;
            end
            // degenerate diagonal -> identity
            id3_next = (arg <= 0);
        end
    end

    // stage 4: sign/magnitude and shift below 2^31
    always_comb
    begin
        logic [qfb_pkg::MAG_W-1:0] mg [4];
        logic hi2, hi1;
        logic [1:0] k;
        hi2 = 1'b0;
        hi1 = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            s4_next.neg[i] = c_reg[i][qfb_pkg::C_W-1];
            mg[i] = qfb_pkg::MAG_W'(c_reg[i][qfb_pkg::C_W-1] ? -c_reg[i] : c_reg[i]);
            hi2 = hi2 | mg[i][32];
            hi1 = hi1 | mg[i][31];
        end
        k = hi2 ? 2'd2 : (hi1 ? 2'd1 : 2'd0);
        for (int i = 0; i < 4; i++)
        begin
            s4_next.mag[i] = qfb_pkg::SMAG_W'(mg[i] >> k);
        end
        s4_next.ident = id3_reg;
    end

    // stage 5: squares; stage 6: sum
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_next[i] = qfb_pkg::SQR_W'(s4_reg.mag[i]) * qfb_pkg::SQR_W'(s4_reg.mag[i]);
        end
        sum_next = (qfb_pkg::SUM_W'(sq_reg[0]) + qfb_pkg::SUM_W'(sq_reg[1]))
                 + (qfb_pkg::SUM_W'(sq_reg[2]) + qfb_pkg::SUM_W'(sq_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            p_reg  <= p_next;
            a1_reg <= a1_next;
            b1_reg <= b1_next;
        end
        if (rdy[1])
        begin
            n_reg  <= n_next;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
        end
        if (rdy[2])
        begin
            c_reg   <= c_next;
            id3_reg <= id3_next;
        end
        if (rdy[3])
        begin
            s4_reg <= s4_next;
        end
        if (rdy[4])
        begin
            sq_reg <= sq_next;
            s5_reg <= s4_reg;
        end
        if (rdy[5])
        begin
            sum_reg <= sum_next;
            s6_reg  <= s5_reg;
        end
    end

endmodule

@@ hdl/qfb_sqrt.sv @@
// ----------------------------------------------------------------------------
// qfb_sqrt: pipelined integer square root
// Digit-by-digit floor square root, STEPS root bits per stage.
// ----------------------------------------------------------------------------
module qfb_sqrt #(
    parameter int STEPS = qfb_pkg::SQRT_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [qfb_pkg::SUM_W-1:0]    in_sumsq,
    input  qfb_pkg::side_t               in_side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [qfb_pkg::ROOT_W-1:0]   out_norm,
    output qfb_pkg::side_t               out_side
);

    localparam int NST = (qfb_pkg::ROOT_W + STEPS - 1) / STEPS;

    logic [NST-1:0] v_reg, v_src;
    logic [NST:0]   rdy;

    logic [qfb_pkg::SUM_W-1:0]  x_reg [NST], x_next [NST], x_src [NST];
    logic [qfb_pkg::REM_W-1:0]  r_reg [NST], r_next [NST], r_src [NST];
    logic [qfb_pkg::ROOT_W-1:0] q_reg [NST], q_next [NST], q_src [NST];
    qfb_pkg::side_t             s_reg [NST], s_src [NST];

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_src[0] = in_valid;
        x_src[0] = in_sumsq;
        r_src[0] = '0;
        q_src[0] = '0;
        s_src[0] = in_side;
        for (int i = 1; i < NST; i++)
        begin
            v_src[i] = v_reg[i-1];
            x_src[i] = x_reg[i-1];
            r_src[i] = r_reg[i-1];
            q_src[i] = q_reg[i-1];
            s_src[i] = s_reg[i-1];
        end
    end

    always_comb
    begin
        logic [qfb_pkg::SUM_W-1:0]  x;
        logic [qfb_pkg::REM_W-1:0]  r, t;
        logic [qfb_pkg::ROOT_W-1:0] q;
        for (int st = 0; st < NST; st++)
        begin
            x = x_src[st];
            r = r_src[st];
            q = q_src[st];
            for (int s = 0; s < STEPS; s++)
            begin
                if (st * STEPS + s < qfb_pkg::ROOT_W)
                begin
                    r = {r[qfb_pkg::REM_W-3:0], x[qfb_pkg::SUM_W-1 -: 2]};
                    x = {x[qfb_pkg::SUM_W-3:0], 2'b00};
                    t = qfb_pkg::REM_W'({q, 2'b01});
                    if (r >= t)
                    begin
                        r = r - t;
                        q = {q[qfb_pkg::ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[qfb_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
            end
            x_next[st] = x;
            r_next[st] = r;
            q_next[st] = q;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_norm  = q_reg[NST-1];
    assign out_side  = s_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_src[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (rdy[i])
            begin
                x_reg[i] <= x_next[i];
                r_reg[i] <= r_next[i];
                q_reg[i] <= q_next[i];
                s_reg[i] <= s_src[i];
            end
        end
    end

endmodule

@@ hdl/qfb_div.sv @@
// ----------------------------------------------------------------------------
// qfb_div: four-lane rounding divider and output register
// q = floor((mag*32768 + norm) / (2*norm)), restoring, STEPS bits per stage,
// then sign, identity override and the output register.
// ----------------------------------------------------------------------------
module qfb_div #(
    parameter int STEPS = qfb_pkg::DIV_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [qfb_pkg::ROOT_W-1:0]   in_norm,
    input  qfb_pkg::side_t               in_side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output qfb_pkg::out_t                quat_w,
    output qfb_pkg::out_t                quat_x,
    output qfb_pkg::out_t                quat_y,
    output qfb_pkg::out_t                quat_z
);

    localparam int NST = (qfb_pkg::QUO_W + STEPS - 1) / STEPS;

    logic [NST-1:0] v_reg, v_src;
    logic [NST:0]   rdy;
    logic           ov_reg;

    logic [3:0][qfb_pkg::DREM_W-1:0] r_reg [NST], r_next [NST], r_src [NST];
    logic [3:0][qfb_pkg::QUO_W-1:0]  q_reg [NST], q_next [NST], q_src [NST];
    logic [qfb_pkg::QUO_W-1:0]       l_reg [NST], l_next [NST], l_src [NST];
    logic [qfb_pkg::DIV_W-1:0]       d_reg [NST], d_src [NST];
    logic [3:0]                      n_reg [NST], n_src [NST];
    logic                            id_reg [NST], id_src [NST];
    qfb_pkg::out_t                   o_reg [4], o_next [4];

    always_comb
    begin
        rdy[NST] = !ov_reg || out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_src[0]  = in_valid;
        d_src[0]  = {in_norm, 1'b0};
        l_src[0]  = in_norm[qfb_pkg::QUO_W-1:0];
        n_src[0]  = in_side.neg;
        id_src[0] = in_side.ident || (in_norm == '0);
        q_src[0]  = '0;
        for (int j = 0; j < 4; j++)
        begin
            r_src[0][j] = qfb_pkg::DREM_W'(in_side.mag[j])
                        + qfb_pkg::DREM_W'(in_norm[qfb_pkg::ROOT_W-1:qfb_pkg::QUO_W]);
        end
        for (int i = 1; i < NST; i++)
        begin
            v_src[i]  = v_reg[i-1];
            d_src[i]  = d_reg[i-1];
            l_src[i]  = l_reg[i-1];
            n_src[i]  = n_reg[i-1];
            id_src[i] = id_reg[i-1];
            q_src[i]  = q_reg[i-1];
            r_src[i]  = r_reg[i-1];
        end
    end

    always_comb
    begin
        logic [qfb_pkg::DREM_W-1:0] r, d;
        logic [qfb_pkg::QUO_W-1:0]  q, l;
        for (int st = 0; st < NST; st++)
        begin
            d = qfb_pkg::DREM_W'(d_src[st]);
            l_next[st] = l_src[st];
            for (int j = 0; j < 4; j++)
            begin
                r = r_src[st][j];
                q = q_src[st][j];
                l = l_src[st];
                for (int s = 0; s < STEPS; s++)
                begin
                    if (st * STEPS + s < qfb_pkg::QUO_W)
                    begin
                        r = {r[qfb_pkg::DREM_W-2:0], l[qfb_pkg::QUO_W-1]};
                        l = {l[qfb_pkg::QUO_W-2:0], 1'b0};
                        if (r >= d)
                        begin
                            r = r - d;
                            q = {q[qfb_pkg::QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            q = {q[qfb_pkg::QUO_W-2:0], 1'b0};
                        end
                    end
                end
                r_next[st][j] = r;
                q_next[st][j] = q;
                l_next[st] = l;
            end
        end
    end

    // sign and identity override
    always_comb
    begin
        qfb_pkg::out_t m;
        for (int j = 0; j < 4; j++)
        begin
            m = qfb_pkg::out_t'({1'b0, q_reg[NST-1][j]});
            o_next[j] = n_reg[NST-1][j] ? -m : m;
        end
        if (id_reg[NST-1])
        begin
            o_next[0] = qfb_pkg::OUT_ONE;
            o_next[1] = '0;
            o_next[2] = '0;
            o_next[3] = '0;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = ov_reg;
    assign quat_w    = o_reg[0];
    assign quat_x    = o_reg[1];
    assign quat_y    = o_reg[2];
    assign quat_z    = o_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_src[i];
                end
            end
            if (rdy[NST])
            begin
                ov_reg <= v_reg[NST-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (rdy[i])
            begin
                r_reg[i]  <= r_next[i];
                q_reg[i]  <= q_next[i];
                l_reg[i]  <= l_next[i];
                d_reg[i]  <= d_src[i];
                n_reg[i]  <= n_src[i];
                id_reg[i] <= id_src[i];
            end
        end
        if (rdy[NST])
        begin
            o_reg <= o_next;
        end
    end

endmodule

@@ hdl/quaternion_from_basis_vectors.sv @@
// ----------------------------------------------------------------------------
// quaternion_from_basis_vectors: rotation matrix to unit quaternion
// Builds the matrix (u, v, u x v) and returns its unit quaternion in Q2.14.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A new beat can be taken every cycle; the
// pipeline fills bubbles when the output stalls, so input ready only drops
// once every stage holds a beat. The pipeline holds six front stages
// (products, cross product, branch select, magnitude/shift, squares, sum),
// the bit-per-step square root, the four-lane divider and the output
// register. Degenerate inputs (failed trace test with a non-positive
// diagonal, or all components zero) return the identity quaternion.
module quaternion_from_basis_vectors #(
    parameter int SQRT_STEPS = qfb_pkg::SQRT_STEPS_DEF,   // root bits per stage
    parameter int DIV_STEPS  = qfb_pkg::DIV_STEPS_DEF     // quotient bits per stage
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  qfb_pkg::in_t  u_x,
    input  qfb_pkg::in_t  u_y,
    input  qfb_pkg::in_t  u_z,
    input  qfb_pkg::in_t  v_x,
    input  qfb_pkg::in_t  v_y,
    input  qfb_pkg::in_t  v_z,
    output logic          out_valid,
    input  logic          out_ready,
    output qfb_pkg::out_t quat_w,
    output qfb_pkg::out_t quat_x,
    output qfb_pkg::out_t quat_y,
    output qfb_pkg::out_t quat_z
);

    // front -> square root
    logic                          f_valid, f_ready;
    logic [qfb_pkg::SUM_W-1:0]     f_sumsq;
    qfb_pkg::side_t                f_side;

    // square root -> divider
    logic                          r_valid, r_ready;
    logic [qfb_pkg::ROOT_W-1:0]    r_norm;
    qfb_pkg::side_t                r_side;

    qfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .u_x       (u_x),
        .u_y       (u_y),
        .u_z       (u_z),
        .v_x       (v_x),
        .v_y       (v_y),
        .v_z       (v_z),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_sumsq (f_sumsq),
        .out_side  (f_side)
    );

    qfb_sqrt #(.STEPS(SQRT_STEPS)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_sumsq  (f_sumsq),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_norm  (r_norm),
        .out_side  (r_side)
    );

    // divider ends in the output register
    qfb_div #(.STEPS(DIV_STEPS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_norm   (r_norm),
        .in_side   (r_side),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z)
    );

endmodule

@@ hdl/qfb_checker.sv @@
// ----------------------------------------------------------------------------
// qfb_checker: port-level checks for quaternion_from_basis_vectors
// Output handshake, result range and pipeline back-pressure behavior.
// ----------------------------------------------------------------------------
module qfb_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input qfb_pkg::in_t  u_x,
    input qfb_pkg::in_t  u_y,
    input qfb_pkg::in_t  u_z,
    input qfb_pkg::in_t  v_x,
    input qfb_pkg::in_t  v_y,
    input qfb_pkg::in_t  v_z,
    input logic          out_valid,
    input logic          out_ready,
    input qfb_pkg::out_t quat_w,
    input qfb_pkg::out_t quat_x,
    input qfb_pkg::out_t quat_y,
    input qfb_pkg::out_t quat_z
);

    // stalled beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(quat_w) && $stable(quat_x)
                                    && $stable(quat_y) && $stable(quat_z))
        else $error("output payload changed while stalled");

    // unit quaternion components stay within +/-1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_w >= -16384 && quat_w <= 16384
                   && quat_x >= -16384 && quat_x <= 16384
                   && quat_y >= -16384 && quat_y <= 16384
                   && quat_z >= -16384 && quat_z <= 16384)
        else $error("quaternion component out of range");

    // a free output slot lets ready reach the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with output slot free");

endmodule

bind quaternion_from_basis_vectors qfb_checker u_qfb_checker (.*);
